/* hdl/mbe_pkg.sv */
`default_nettype none

package mbe_pkg;

  // Field widths fixed by the interface
  localparam int PIXEL_BITS   = 12;
  localparam int COORD_W      = 32;
  localparam int COUNT_W      = 16;
  localparam int RADIUS_W     = 32;
  localparam int CFG_IDX_BITS = 3;

  localparam int COORD_BITS_DEFAULT = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_STEP          = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_STEP          = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_ORIGIN        = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_ORIGIN        = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_LIMIT_SQ = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ITERATION_LIMIT = 3'd5;

  // Reset values
  localparam logic [COORD_W-1:0]  X_STEP_RST          = 32'h0004_0000;
  localparam logic [COORD_W-1:0]  Y_STEP_RST          = 32'h0004_0000;
  localparam logic [COORD_W-1:0]  X_ORIGIN_RST        = 32'hE000_0000;
  localparam logic [COORD_W-1:0]  Y_ORIGIN_RST        = 32'hE000_0000;
  localparam logic [RADIUS_W-1:0] RADIUS_LIMIT_SQ_RST = 32'h0400_0000;
  localparam logic [COUNT_W-1:0]  ITERATION_LIMIT_RST = 16'd256;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_step;
    logic signed [COORD_W-1:0] y_step;
    logic signed [COORD_W-1:0] x_origin;
    logic signed [COORD_W-1:0] y_origin;
    logic [RADIUS_W-1:0]       radius_limit_sq;
    logic [COUNT_W-1:0]        iteration_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_pixel;
    logic mul_en;
    logic mul_map;
    logic map_add;
    logic iter_upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic escaped;
    logic last_iter;
    logic limit_zero;
  } status_t;

  // Clamp a wide signed value into Q4.28
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* hdl/mbe_cfg.sv */
`default_nettype none

module mbe_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mbe_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [31:0]                       cfg_data,
  output mbe_pkg::cfg_t                          cfg
);

  assign cfg_ready = 1'b1;

  // Drop writes beyond the register list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_step          <= mbe_pkg::X_STEP_RST;
      cfg.y_step          <= mbe_pkg::Y_STEP_RST;
      cfg.x_origin        <= mbe_pkg::X_ORIGIN_RST;
      cfg.y_origin        <= mbe_pkg::Y_ORIGIN_RST;
      cfg.radius_limit_sq <= mbe_pkg::RADIUS_LIMIT_SQ_RST;
      cfg.iteration_limit <= mbe_pkg::ITERATION_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbe_pkg::CFG_X_STEP:          cfg.x_step          <= cfg_data;
        mbe_pkg::CFG_Y_STEP:          cfg.y_step          <= cfg_data;
        mbe_pkg::CFG_X_ORIGIN:        cfg.x_origin        <= cfg_data;
        mbe_pkg::CFG_Y_ORIGIN:        cfg.y_origin        <= cfg_data;
        mbe_pkg::CFG_RADIUS_LIMIT_SQ: cfg.radius_limit_sq <= cfg_data;
        mbe_pkg::CFG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[mbe_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/mbe_ctrl.sv */
`default_nettype none

module mbe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire mbe_pkg::status_t status,
  output mbe_pkg::cmd_t         cmd
);

  mbe_pkg::state_t state;
  mbe_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbe_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != mbe_pkg::ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      mbe_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_pixel = 1'b1;
          state_next     = mbe_pkg::ST_MAP_MUL;
        end
      end
      mbe_pkg::ST_MAP_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_map = 1'b1;
        state_next  = mbe_pkg::ST_MAP_ADD;
      end
      mbe_pkg::ST_MAP_ADD: begin
        cmd.map_add = 1'b1;
        state_next  = status.limit_zero ? mbe_pkg::ST_FINISH : mbe_pkg::ST_ITER_MUL;
      end
      mbe_pkg::ST_ITER_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = mbe_pkg::ST_ITER_UPD;
      end
      mbe_pkg::ST_ITER_UPD: begin
        cmd.iter_upd = 1'b1;
        if (status.escaped || status.last_iter) begin
          state_next = mbe_pkg::ST_FINISH;
        end else begin
          state_next = mbe_pkg::ST_ITER_MUL;
        end
      end
      mbe_pkg::ST_FINISH: begin
        // Hold until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = mbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/mbe_dp.sv */
`default_nettype none

module mbe_dp #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire mbe_pkg::cfg_t                       cfg,
  input  wire mbe_pkg::cmd_t                       cmd,
  input  wire logic [mbe_pkg::PIXEL_BITS-1:0]      pixel_row,
  input  wire logic [mbe_pkg::PIXEL_BITS-1:0]      pixel_col,
  output mbe_pkg::status_t                         status,
  output logic [mbe_pkg::COUNT_W-1:0]              escape_count,
  output logic [mbe_pkg::RADIUS_W-1:0]             last_radius_sq
);

  localparam int USED_BITS = (COORD_BITS < mbe_pkg::PIXEL_BITS) ? COORD_BITS
                                                                 : mbe_pkg::PIXEL_BITS;
  localparam int CW = mbe_pkg::COORD_W;

  logic [USED_BITS-1:0]         row;
  logic [USED_BITS-1:0]         col;
  logic signed [CW-1:0]         cre;
  logic signed [CW-1:0]         cim;
  logic signed [CW-1:0]         x;
  logic signed [CW-1:0]         y;
  logic [mbe_pkg::COUNT_W-1:0]  count;
  logic [mbe_pkg::RADIUS_W-1:0] radius;

  logic signed [CW-1:0] ma0, mb0, ma1, mb1, ma2, mb2;
  logic signed [63:0]   prod0, prod1, prod2;
  logic signed [63:0]   p0, p1, p2;

  logic signed [63:0]   map_re, map_im;
  logic [63:0]          mag;
  logic [mbe_pkg::RADIUS_W-1:0] radius_calc;
  logic signed [63:0]   diff;
  logic signed [63:0]   x_sum, y_sum;

  // Operand select: pixel mapping or z squared
  always_comb begin
    if (cmd.mul_map) begin
      ma0 = signed'({{(CW-USED_BITS){1'b0}}, col});
      mb0 = cfg.x_step;
      ma1 = signed'({{(CW-USED_BITS){1'b0}}, row});
      mb1 = cfg.y_step;
    end else begin
      ma0 = x;
      mb0 = x;
      ma1 = y;
      mb1 = y;
    end
    ma2 = x;
    mb2 = y;
  end

  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;
  assign prod2 = ma2 * mb2;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p0 <= prod0;
      p1 <= prod1;
      p2 <= prod2;
    end
  end

  assign map_re = {{32{cfg.x_origin[CW-1]}}, cfg.x_origin} + p0;
  assign map_im = {{32{cfg.y_origin[CW-1]}}, cfg.y_origin} + p1;

  // Both squares are non-negative, so their sum is at most 2^63
  assign mag         = unsigned'(p0) + unsigned'(p1);
  assign radius_calc = mag[63:32];
  assign diff        = p0 - p1;
  // Keep the whole sum signed so the shifts round towards minus infinity
  assign x_sum       = (diff >>> 28) + signed'({{32{cre[CW-1]}}, cre});
  assign y_sum       = (p2 >>> 27) + signed'({{32{cim[CW-1]}}, cim});

  assign status.escaped    = (radius_calc > cfg.radius_limit_sq);
  assign status.last_iter  = (({1'b0, count} + 17'd1) == {1'b0, cfg.iteration_limit});
  assign status.limit_zero = (cfg.iteration_limit == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      row <= pixel_row[USED_BITS-1:0];
      col <= pixel_col[USED_BITS-1:0];
    end
    if (cmd.map_add) begin
      cre    <= mbe_pkg::sat32(map_re);
      cim    <= mbe_pkg::sat32(map_im);
      x      <= mbe_pkg::sat32(map_re);
      y      <= mbe_pkg::sat32(map_im);
      count  <= '0;
      radius <= '0;
    end
    if (cmd.iter_upd) begin
      radius <= radius_calc;
      if (!status.escaped) begin
        count <= count + 16'd1;
        x     <= mbe_pkg::sat32(x_sum);
        y     <= mbe_pkg::sat32(y_sum);
      end
    end
    if (cmd.load_out) begin
      escape_count   <= count;
      last_radius_sq <= radius;
    end
  end

endmodule

`default_nettype wire

/* hdl/mandelbrot_escape_time.sv */
// Mandelbrot escape-time pixel engine.
// Input channel: one word per pixel (pixel_row, pixel_col), taken when in_valid
// is high and in_stall low. Each pixel maps to c = origin + index * step in
// signed Q4.28 and iterates z = z*z + c from z = c.
// Output channel: one word per pixel (escape_count, last_radius_sq), taken when
// out_valid is high and out_stall low.
// Configuration: write cfg_data to register cfg_index while cfg_valid is high;
// cfg_ready is always high. Indexes beyond the list are ignored. Write only
// while no pixel is in flight and no result is waiting.
// Iteration: a registered 32x32 multiply of x*x, y*y and x*y, followed by
// the radius test and z update. The reset iteration limit is 256.
// One pixel is worked at a time; the next is taken as soon as the result has
// moved to the output register, even while that register is stalled.
// Reset: synchronous, clears the controller and loads the register defaults.
// A stalled result holds; a finished pixel waits until the register is free.
`default_nettype none

module mandelbrot_escape_time #(
  parameter int COORD_BITS = mbe_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mbe_pkg::PIXEL_BITS-1:0]     pixel_row,
  input  wire logic [mbe_pkg::PIXEL_BITS-1:0]     pixel_col,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mbe_pkg::COUNT_W-1:0]             escape_count,
  output logic [mbe_pkg::RADIUS_W-1:0]            last_radius_sq,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mbe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  mbe_pkg::cfg_t    cfg;
  mbe_pkg::cmd_t    cmd;
  mbe_pkg::status_t status;

  // Register file
  mbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: map, iterate, hand over to the output register
  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Multipliers, saturating adders, radius compare, iteration counter
  mbe_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .cfg            (cfg),
    .cmd            (cmd),
    .pixel_row      (pixel_row),
    .pixel_col      (pixel_col),
    .status         (status),
    .escape_count   (escape_count),
    .last_radius_sq (last_radius_sq)
  );

`ifndef SYNTH
  // The count never runs past the iteration limit
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (escape_count <= cfg.iteration_limit))
    else $error("escape_count exceeds iteration_limit");

  // Stopping short of the limit means the radius crossed the threshold
  a_escape_radius: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (escape_count < cfg.iteration_limit))
      |-> (last_radius_sq > cfg.radius_limit_sq))
    else $error("early stop without escape");

  // One pixel at a time: an accepted word closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a pixel is in flight");
`endif

endmodule

`default_nettype wire
